// ----- sv/alht_pkg.sv -----
// ----------------------------------------------------------------------------
// alht_pkg
// Shared types and constants for the address-to-label hash table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package alht_pkg;

  localparam int TABLE_SLOTS_DEF = 2003;
  localparam int ADDR_W          = 16;
  localparam int LABEL_W         = 16;
  localparam int SLOT_FW         = 11;
  localparam int PROBE_FW        = 12;
  localparam int HASH_MULT       = 3;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [ADDR_W-1:0]  address;
    logic [LABEL_W-1:0] label_id;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [SLOT_FW-1:0]  slot;
    logic [LABEL_W-1:0]  label_out;
    logic                overflow;
    logic [PROBE_FW-1:0] probes;
  } out_item_t;

  typedef struct packed {
    logic               used;
    logic [ADDR_W-1:0]  key;
    logic [LABEL_W-1:0] label;
  } slot_entry_t;

  typedef struct packed {
    logic push;
    logic full;
  } push_ctl_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } pop_ctl_t;

endpackage

`default_nettype wire

// ----- sv/alht_queue.sv -----
// ----------------------------------------------------------------------------
// alht_queue
// Two-entry queue between the hashing front end and the probe engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alht_queue #(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] din,
  output logic               full,
  input  wire logic          pop,
  output logic [DW-1:0]      dout,
  output logic               empty
);

  logic [DW-1:0] ent_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !full) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop && !empty) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if ((push && !full) && !(pop && !empty)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!(push && !full) && (pop && !empty)) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      ent_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

// ----- sv/alht_front.sv -----
// ----------------------------------------------------------------------------
// alht_front
// Accepts items and computes the home slot (address*3 mod slots) by
// reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alht_front #(
  parameter int TABLE_SLOTS = alht_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           clearing,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire alht_pkg::in_item_t             in_item,
  output alht_pkg::push_ctl_t                 q_ctl,
  input  wire logic                           q_full,
  output alht_pkg::in_item_t                  q_item,
  output logic [$clog2(TABLE_SLOTS)-1:0]      q_slot
);

  import alht_pkg::*;

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int RW = SW + 1;
  localparam int XW = ADDR_W + 2;
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / TABLE_SLOTS);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_QUOT = 4'b0010,
    F_REM  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t        state_r, state_nxt;
  in_item_t       item_r;
  logic [XW-1:0]  x_r;
  logic [XW-1:0]  q_r;
  logic [RW-1:0]  rem_r;
  logic [XW+31:0] prod;
  logic [XW-1:0]  qn;
  logic           accept;

  assign in_stall = (state_r != F_IDLE) || clearing;
  assign accept   = in_valid && !in_stall;
  assign prod     = (XW+32)'(x_r) * (XW+32)'(RECIP);
  assign qn       = q_r * XW'(TABLE_SLOTS);

  assign q_item     = item_r;
  assign q_slot     = (rem_r >= RW'(TABLE_SLOTS)) ? SW'(rem_r - RW'(TABLE_SLOTS))
                                                  : SW'(rem_r);
  assign q_ctl.push = (state_r == F_PUSH) && !q_full;
  assign q_ctl.full = q_full;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (accept) state_nxt = F_QUOT;
      F_QUOT:  state_nxt = F_REM;
      F_REM:   state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
      x_r    <= XW'({in_item.address, 1'b0}) + XW'(in_item.address);
    end
    if (state_r == F_QUOT) begin
      q_r <= prod[XW+31:32];
    end
    if (state_r == F_REM) begin
      rem_r <= RW'(x_r - qn);
    end
  end

endmodule

`default_nettype wire

// ----- sv/alht_back.sv -----
// ----------------------------------------------------------------------------
// alht_back
// Probe engine: owns the slot memory, clears it after reset, walks the
// probe chain one slot per cycle, writes inserts and drives the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alht_back #(
  parameter int TABLE_SLOTS = alht_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  output logic                                clearing,
  output alht_pkg::pop_ctl_t                  q_ctl,
  input  wire logic                           q_empty,
  input  wire alht_pkg::in_item_t             q_item,
  input  wire logic [$clog2(TABLE_SLOTS)-1:0] q_slot,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output alht_pkg::out_item_t                 out_item
);

  import alht_pkg::*;

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int PW = $clog2(2 * TABLE_SLOTS + 2);
  localparam logic [PW-1:0] LIMIT = PW'(2 * TABLE_SLOTS);

  typedef enum logic [4:0] {
    B_CLEAR = 5'b00001,
    B_IDLE  = 5'b00010,
    B_READ  = 5'b00100,
    B_CHECK = 5'b01000,
    B_EMIT  = 5'b10000
  } bstate_t;

  slot_entry_t     mem [TABLE_SLOTS];
  slot_entry_t     rd_data_r;
  logic [SW-1:0]   rd_addr;
  logic            we;
  logic [SW-1:0]   waddr;
  slot_entry_t     wdata;

  bstate_t         state_r, state_nxt;
  logic [SW-1:0]   clr_r;
  in_item_t        cur_r;
  logic [SW-1:0]   slot_r;
  logic [PW-1:0]   probes_r;
  out_item_t       res_r;
  logic            out_valid_r;
  out_item_t       out_item_r;

  logic [SW+1:0]   s3;
  logic [SW-1:0]   nxt_slot;
  logic            hit, miss, ovf, done;
  logic [31:0]     slot_wide;
  logic [31:0]     probes_wide;
  logic            out_free;

  assign clearing    = (state_r == B_CLEAR);
  assign q_ctl.pop   = (state_r == B_IDLE) && !q_empty;
  assign q_ctl.empty = q_empty;
  assign out_valid   = out_valid_r;
  assign out_item    = out_item_r;
  assign out_free    = !out_valid_r || !out_stall;

  assign s3 = (SW+2)'(slot_r) + (SW+2)'({slot_r, 1'b0});
  always_comb begin
    if (s3 >= (SW+2)'(2 * TABLE_SLOTS)) begin
      nxt_slot = SW'(s3 - (SW+2)'(2 * TABLE_SLOTS));
    end else if (s3 >= (SW+2)'(TABLE_SLOTS)) begin
      nxt_slot = SW'(s3 - (SW+2)'(TABLE_SLOTS));
    end else begin
      nxt_slot = SW'(s3);
    end
  end

  assign miss = !rd_data_r.used;
  assign hit  = rd_data_r.used && (rd_data_r.key == cur_r.address);
  assign ovf  = !miss && !hit && (probes_r == LIMIT);
  assign done = miss || hit || ovf;

  assign rd_addr     = (state_r == B_CHECK) ? nxt_slot : slot_r;
  assign slot_wide   = 32'(slot_r);
  assign probes_wide = 32'(probes_r + PW'(ovf));

  always_comb begin
    we    = 1'b0;
    waddr = slot_r;
    wdata = '{used: 1'b1, key: cur_r.address, label: cur_r.label_id};
    if (state_r == B_CLEAR) begin
      we    = 1'b1;
      waddr = clr_r;
      wdata = '0;
    end else if (state_r == B_CHECK && done && !ovf &&
                 cur_r.operation == OP_INSERT) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_CLEAR: if (clr_r == SW'(TABLE_SLOTS - 1)) state_nxt = B_IDLE;
      B_IDLE:  if (!q_empty) state_nxt = B_READ;
      B_READ:  state_nxt = B_CHECK;
      B_CHECK: if (done) state_nxt = B_EMIT;
      B_EMIT:  if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CLEAR) begin
        clr_r <= clr_r + SW'(1);
      end
      if (state_r == B_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && !q_empty) begin
      cur_r    <= q_item;
      slot_r   <= q_slot;
      probes_r <= PW'(1);
    end
    if (state_r == B_CHECK) begin
      if (done) begin
        res_r.found     <= hit;
        res_r.slot      <= slot_wide[SLOT_FW-1:0];
        res_r.label_out <= hit ? rd_data_r.label : '0;
        res_r.overflow  <= ovf;
        res_r.probes    <= probes_wide[PROBE_FW-1:0];
      end else begin
        slot_r   <= nxt_slot;
        probes_r <= probes_r + PW'(1);
      end
    end
    if (state_r == B_EMIT && out_free) begin
      out_item_r <= res_r;
    end
  end

endmodule

`default_nettype wire

// ----- sv/address_label_hash_table_core.sv -----
// ----------------------------------------------------------------------------
// address_label_hash_table_core
// Open-addressing map from a 16-bit address to a 16-bit label id.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (in_item: operation, address, label_id) enter on in_valid
//   when in_stall is low. A lookup reports found, slot and stored label; an
//   insert also writes the address and label at the slot where probing
//   stopped, unless the probe limit overflowed. One result item leaves per
//   input item on out_valid/out_stall. After reset the slot memory is swept
//   empty, one slot per cycle; in_stall stays high during the sweep.
//   The front end forms the home slot in F_QUOT, F_REM and F_PUSH (two
//   registered multiplies and a correction) and takes no new item until it
//   has pushed the last; a two-item queue follows. The probe engine then
//   passes B_IDLE, B_READ, one B_CHECK per examined slot and B_EMIT, bound
//   by the single read port of the slot memory (one probe per cycle). A
//   stalled result holds in the output register while the next item is
//   accepted and hashed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module address_label_hash_table_core #(
  parameter int TABLE_SLOTS = alht_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire alht_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output alht_pkg::out_item_t      out_item
);

  import alht_pkg::*;

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int QW = $bits(in_item_t) + SW;

  logic          clearing;
  push_ctl_t     push_ctl;
  pop_ctl_t      pop_ctl;
  logic          q_full;
  logic          q_empty;
  in_item_t      f_item;
  logic [SW-1:0] f_slot;
  logic [QW-1:0] q_dout;
  in_item_t      b_item;
  logic [SW-1:0] b_slot;

  assign b_item = q_dout[QW-1:SW];
  assign b_slot = q_dout[SW-1:0];

  alht_front #(.TABLE_SLOTS(TABLE_SLOTS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .clearing (clearing),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_ctl    (push_ctl),
    .q_full   (q_full),
    .q_item   (f_item),
    .q_slot   (f_slot)
  );

  alht_queue #(.DW(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push_ctl.push),
    .din   ({f_item, f_slot}),
    .full  (q_full),
    .pop   (pop_ctl.pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  alht_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clearing  (clearing),
    .q_ctl     (pop_ctl),
    .q_empty   (q_empty),
    .q_item    (b_item),
    .q_slot    (b_slot),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // status members kept for observability of the queue boundary
  logic unused_ok;
  assign unused_ok = push_ctl.full ^ pop_ctl.empty;

endmodule

`default_nettype wire

// ----- sv/alht_checker.sv -----
// ----------------------------------------------------------------------------
// alht_port_checks
// Port-level checks for the address-to-label hash table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alht_port_checks #(
  parameter int TABLE_SLOTS = alht_pkg::TABLE_SLOTS_DEF
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire alht_pkg::in_item_t  in_item,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire alht_pkg::out_item_t out_item
);

  import alht_pkg::*;

  localparam logic [31:0] OVF_PROBES_W = 32'(2 * TABLE_SLOTS + 1);
  localparam logic [PROBE_FW-1:0] OVF_PROBES = OVF_PROBES_W[PROBE_FW-1:0];

  logic unused_in;
  assign unused_in = in_valid ^ (^in_item);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_ovf_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.overflow |-> !out_item.found &&
      out_item.probes == OVF_PROBES)
    else $error("overflow result inconsistent");

  a_miss_label: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.found |-> out_item.label_out == '0)
    else $error("label reported without a hit");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> in_stall)
    else $error("item taken before table clear");

endmodule

bind address_label_hash_table_core alht_port_checks #(.TABLE_SLOTS(TABLE_SLOTS))
  u_alht_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire

// ----- dv/alht_checker.sv -----
// ----------------------------------------------------------------------------
// alht_checker
// Watches both channels of the address-to-label hash table, keeps its own
// copy of the slot table, predicts each result item and compares it field by
// field with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alht_checker #(
  parameter int TABLE_SLOTS = alht_pkg::TABLE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  alht_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  alht_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  waiting,
  output int                  checked,
  output int                  hit_count,
  output int                  overflow_count
);

  import alht_pkg::*;

  bit                 slot_taken [TABLE_SLOTS];
  logic [ADDR_W-1:0]  slot_addr  [TABLE_SLOTS];
  logic [LABEL_W-1:0] slot_lbl   [TABLE_SLOTS];

  out_item_t pending_results [$];
  int        errs;
  int        n_checked;
  int        n_hits;
  int        n_ovf;

  // Probe for the address, apply an insert, return the result item.
  function automatic out_item_t probe_table(input in_item_t it);
    out_item_t r;
    int        idx;
    int        extra;
    bit        hit;
    bit        ovf;
    r     = '0;
    idx   = (int'(it.address) * HASH_MULT) % TABLE_SLOTS;
    extra = 0;
    hit   = 1'b0;
    ovf   = 1'b0;
    while (slot_taken[idx] && !hit && !ovf) begin
      if (slot_addr[idx] == it.address) begin
        hit = 1'b1;
      end else begin
        extra++;
        if (extra >= 2 * TABLE_SLOTS) begin
          ovf = 1'b1;
        end else begin
          idx = (idx * HASH_MULT) % TABLE_SLOTS;
        end
      end
    end
    r.found     = hit;
    r.slot      = idx[SLOT_FW-1:0];
    r.label_out = hit ? slot_lbl[idx] : '0;
    r.overflow  = ovf;
    r.probes    = PROBE_FW'(extra + 1);
    if (it.operation == OP_INSERT && !ovf) begin
      slot_taken[idx] = 1'b1;
      slot_addr[idx]  = it.address;
      slot_lbl[idx]   = it.label_id;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errs++;
    end
  endtask

  initial begin
    errs      = 0;
    n_checked = 0;
    n_hits    = 0;
    n_ovf     = 0;
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SLOTS; i++) slot_taken[i] = 1'b0;
      pending_results.delete();
    end else begin
      if (in_valid && !in_stall) pending_results.push_back(probe_table(in_item));
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result item, expected none, got %h", $time, out_item);
          errs++;
        end else begin
          exp_r = pending_results.pop_front();
          n_checked++;
          check_field("found", exp_r.found, out_item.found);
          check_field("slot", exp_r.slot, out_item.slot);
          check_field("label_out", exp_r.label_out, out_item.label_out);
          check_field("overflow", exp_r.overflow, out_item.overflow);
          check_field("probes", exp_r.probes, out_item.probes);
          if (exp_r.found) n_hits++;
          if (exp_r.overflow) n_ovf++;
        end
      end
    end
    fail_count     <= errs;
    waiting        <= pending_results.size();
    checked        <= n_checked;
    hit_count      <= n_hits;
    overflow_count <= n_ovf;
  end

endmodule

// ----- dv/address_label_hash_table_core_tb.sv -----
// ----------------------------------------------------------------------------
// address_label_hash_table_core_tb
// Drives lookups and inserts into the hash table core: a directed set for
// overwrite, collision chains and the probe limit on slot 0, then random
// phases over a small address pool with random idling, a long output stall
// and idle pauses. Results are checked by alht_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module address_label_hash_table_core_tb;

  import alht_pkg::*;

  localparam int CYCLE_LIMIT  = 16_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int POOL_SIZE    = 48;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 100;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  int fail_count;
  int waiting;
  int checked;
  int hit_count;
  int overflow_count;

  int sent;
  int cycle_count;
  bit quiet_tx;
  bit quiet_rx;
  bit hold_rx;

  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

  address_label_hash_table_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  alht_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .fail_count     (fail_count),
    .waiting        (waiting),
    .checked        (checked),
    .hit_count      (hit_count),
    .overflow_count (overflow_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Verification failed");
    $finish;
  end

  function automatic in_item_t item_of(input op_t op, input int addr, input int lbl);
    in_item_t it;
    it.operation = op;
    it.address   = ADDR_W'(addr);
    it.label_id  = LABEL_W'(lbl);
    return it;
  endfunction

  // Mostly pool addresses with colliding aliases (same home slot), a rare
  // slot-0 address, and the rest uniform.
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    pick         = $urandom_range(0, 99);
    it.operation = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_LOOKUP;
    it.label_id  = LABEL_W'($urandom);
    if (pick < 60) begin
      it.address = addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                   + ADDR_W'(2003 * $urandom_range(0, 3));
    end else if (pick == 60) begin
      it.address = ADDR_W'(2003 * $urandom_range(0, 32));
    end else begin
      it.address = ADDR_W'($urandom);
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_rx) begin
        n       = HOLD_CYCLES;
        hold_rx = 1'b0;
      end else begin
        n = quiet_rx ? 0 : $urandom_range(0, 17);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  initial begin : stimulus
    in_item_t plan [$];
    int       b;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
    hold_rx  = 1'b0;
    sent     = 0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      do b = $urandom_range(1, 65535 - 3 * 2003); while (b % 2003 == 0);
      addr_pool[i] = ADDR_W'(b);
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, extremes, overwrite
    plan.push_back(item_of(OP_LOOKUP, 0, 16'hFFFF));
    plan.push_back(item_of(OP_INSERT, 16'hFFFF, 16'hFFFF));
    plan.push_back(item_of(OP_LOOKUP, 16'hFFFF, 0));
    plan.push_back(item_of(OP_INSERT, 16'hFFFF, 0));
    plan.push_back(item_of(OP_LOOKUP, 16'hFFFF, 16'h1234));
    // slot 0 taken, then address 0 and another slot-0 alias hit the probe limit
    plan.push_back(item_of(OP_INSERT, 2003, 16'h1234));
    plan.push_back(item_of(OP_LOOKUP, 0, 0));
    plan.push_back(item_of(OP_INSERT, 0, 16'hAAAA));
    plan.push_back(item_of(OP_LOOKUP, 0, 0));
    plan.push_back(item_of(OP_INSERT, 4006, 16'h5555));
    plan.push_back(item_of(OP_LOOKUP, 2003, 0));
    // collision chain on one home slot
    plan.push_back(item_of(OP_INSERT, 1, 16'h0101));
    plan.push_back(item_of(OP_INSERT, 1 + 2003, 16'h0202));
    plan.push_back(item_of(OP_INSERT, 1 + 2 * 2003, 16'h0303));
    plan.push_back(item_of(OP_LOOKUP, 1 + 2 * 2003, 0));
    plan.push_back(item_of(OP_LOOKUP, 1 + 3 * 2003, 0));
    plan.push_back(item_of(OP_INSERT, 1 + 2003, 16'h8000));
    plan.push_back(item_of(OP_LOOKUP, 1, 16'hFFFF));
    plan.push_back(item_of(OP_INSERT, 16'h5555, 16'h5555));
    plan.push_back(item_of(OP_INSERT, 16'hAAAA, 16'hAAAA));
    plan.push_back(item_of(OP_LOOKUP, 16'h5555, 0));
    plan.push_back(item_of(OP_LOOKUP, 16'hAAAA, 0));
    foreach (plan[k]) send_item(plan[k]);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      quiet_tx = (p == 1) || (p == 3) || (p == 4);
      quiet_rx = (p == 2) || (p == 3);
      if (p == 4) hold_rx = 1'b1;
      repeat (PHASE_ITEMS) send_item(random_item());
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items; checked %0d results, %0d hits, %0d probe-limit overflows.",
             sent, checked, hit_count, overflow_count);
    $display("Phases mixed random idling, idle-free stretches and one long output stall.");
    if (fail_count == 0 && waiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/alht_pkg.sv
sv/alht_queue.sv
sv/alht_front.sv
sv/alht_back.sv
sv/address_label_hash_table_core.sv
sv/alht_checker.sv
dv/alht_checker.sv
dv/address_label_hash_table_core_tb.sv
